FILE: rtl/fusd_pkg.sv
// shared types and codes for the firmware update stream deframer
// no dependencies
`default_nettype none

package fusd_pkg;

  localparam int unsigned CFG_COUNT = 4;
  localparam int unsigned CFG_IDX_W = 2;

  typedef logic [1:0] cmd_t;
  typedef logic [1:0] status_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cmd_t CMD_FEED  = 2'd0;
  localparam cmd_t CMD_CLEAR = 2'd1;
  localparam cmd_t CMD_ABORT = 2'd2;

  localparam status_t STAT_INCOMPLETE = 2'd0;
  localparam status_t STAT_COMPLETE   = 2'd1;
  localparam status_t STAT_INVALID    = 2'd2;

  localparam cfg_idx_t CFG_START_WORD   = 2'd0;
  localparam cfg_idx_t CFG_VERSION_WORD = 2'd1;
  localparam cfg_idx_t CFG_TARGET_ID    = 2'd2;
  localparam cfg_idx_t CFG_END_WORD     = 2'd3;

  localparam logic [3:0] MARKER_BYTES = 4'd4;
  localparam logic [3:0] META_BYTES   = 4'd12;

  typedef struct packed {
    cmd_t       command;
    logic [7:0] data_byte;
    logic       sink_accepts;
  } item_t;

  typedef struct packed {
    status_t     status;
    logic        begin_strobe;
    logic        write_strobe;
    logic [7:0]  write_byte;
    logic        finish_strobe;
    logic        abort_strobe;
    logic [31:0] frame_size;
    logic [31:0] write_count;
  } result_t;

endpackage

`default_nettype wire

FILE: rtl/fusd_in_reg.sv
// input register for the byte channel
// depends on fusd_pkg
`default_nettype none

module fusd_in_reg (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          feed_valid,
  output logic               feed_stall,
  input  wire fusd_pkg::item_t feed_item,
  input  wire logic          advance,
  output logic               held_valid,
  output fusd_pkg::item_t    held_item
);
  import fusd_pkg::*;

  logic load;

  assign feed_stall = held_valid && !advance;
  assign load       = feed_valid && !feed_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (load) begin
      held_valid <= 1'b1;
    end else if (advance) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held_item <= feed_item;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/fusd_core.sv
// parser state, configuration registers and per-byte next-state logic
// depends on fusd_pkg
`default_nettype none

module fusd_core (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr_en,
  input  wire fusd_pkg::cfg_idx_t wr_index,
  input  wire logic [31:0]      wr_data,
  input  wire logic             fire,
  input  wire fusd_pkg::item_t  item,
  output fusd_pkg::result_t     result
);
  import fusd_pkg::*;

  typedef enum logic [2:0] {
    ST_START,
    ST_META,
    ST_PAYLOAD,
    ST_END,
    ST_DONE
  } stage_t;

  logic [31:0] start_word, version_word, target_id, end_word;

  stage_t      stage, stage_next;
  status_t     latched_status, latched_status_next;
  logic [3:0]  byte_count, byte_count_next;
  logic [31:0] got_version, got_version_next;
  logic [31:0] got_target, got_target_next;
  logic [31:0] size_word, size_word_next;
  logic [31:0] payload_count, payload_count_next;
  logic        sink_active, sink_active_next;

  status_t     r;
  logic [3:0]  count_inc;
  logic [31:0] pc_inc;
  logic [4:0]  bsel;
  logic        b_s, w_s, f_s, a_s;
  logic [7:0]  w_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_word   <= '0;
      version_word <= '0;
      target_id    <= '0;
      end_word     <= '0;
    end else if (wr_en) begin
      unique case (wr_index)
        CFG_START_WORD:   start_word   <= wr_data;
        CFG_VERSION_WORD: version_word <= wr_data;
        CFG_TARGET_ID:    target_id    <= wr_data;
        CFG_END_WORD:     end_word     <= wr_data;
        default: ;
      endcase
    end
  end

  assign count_inc = byte_count + 4'd1;
  assign pc_inc    = payload_count + 32'd1;
  assign bsel      = {byte_count[1:0], 3'b000};

  always_comb begin
    stage_next          = stage;
    latched_status_next = latched_status;
    byte_count_next     = byte_count;
    got_version_next    = got_version;
    got_target_next     = got_target;
    size_word_next      = size_word;
    payload_count_next  = payload_count;
    sink_active_next    = sink_active;
    r   = STAT_INVALID;
    b_s = 1'b0;
    w_s = 1'b0;
    w_b = 8'd0;
    f_s = 1'b0;
    a_s = 1'b0;

    case (item.command) inside
      CMD_CLEAR, CMD_ABORT: begin
        a_s                 = (item.command == CMD_ABORT);
        stage_next          = ST_START;
        latched_status_next = STAT_INCOMPLETE;
        byte_count_next     = '0;
        got_version_next    = '0;
        got_target_next     = '0;
        size_word_next      = '0;
        payload_count_next  = '0;
        sink_active_next    = 1'b0;
      end
      CMD_FEED: begin
        if (latched_status != STAT_INVALID) begin
          unique case (stage)
            ST_START: begin
              if (start_word[bsel +: 8] == item.data_byte) begin
                byte_count_next = count_inc;
                r = (count_inc == MARKER_BYTES) ? STAT_COMPLETE : STAT_INCOMPLETE;
              end
            end
            ST_META: begin
              case (byte_count[3:2])
                2'd0: got_version_next[bsel +: 8] = got_version[bsel +: 8] | item.data_byte;
                2'd1: got_target_next[bsel +: 8]  = got_target[bsel +: 8] | item.data_byte;
                2'd2: size_word_next[bsel +: 8]   = size_word[bsel +: 8] | item.data_byte;
                default: ;
              endcase
              byte_count_next = count_inc;
              if (count_inc != META_BYTES) begin
                r = STAT_INCOMPLETE;
              end else if (got_version_next == version_word &&
                           got_target_next == target_id && size_word_next != '0) begin
                b_s = 1'b1;
                if (item.sink_accepts) begin
                  sink_active_next = 1'b1;
                  r = STAT_COMPLETE;
                end
              end
            end
            ST_PAYLOAD: begin
              w_s = 1'b1;
              w_b = item.data_byte;
              if (item.sink_accepts) begin
                payload_count_next = pc_inc;
                r = (pc_inc == size_word) ? STAT_COMPLETE : STAT_INCOMPLETE;
              end
            end
            ST_END: begin
              if (end_word[bsel +: 8] == item.data_byte) begin
                byte_count_next = count_inc;
                if (count_inc == MARKER_BYTES) begin
                  f_s = 1'b1;
                  r = item.sink_accepts ? STAT_COMPLETE : STAT_INVALID;
                end else begin
                  r = STAT_INCOMPLETE;
                end
              end
            end
            default: r = STAT_INVALID;
          endcase

          if (r == STAT_COMPLETE) begin
            if (stage == ST_END) begin
              stage_next          = ST_DONE;
              sink_active_next    = 1'b0;
              latched_status_next = STAT_COMPLETE;
            end else begin
              byte_count_next     = '0;
              latched_status_next = STAT_INCOMPLETE;
              unique case (stage)
                ST_START:   stage_next = ST_META;
                ST_META:    stage_next = ST_PAYLOAD;
                default:    stage_next = ST_END;
              endcase
            end
          end else if (r == STAT_INVALID) begin
            a_s                 = sink_active;
            stage_next          = ST_START;
            latched_status_next = STAT_INVALID;
            byte_count_next     = '0;
            got_version_next    = '0;
            got_target_next     = '0;
            size_word_next      = '0;
            payload_count_next  = '0;
            sink_active_next    = 1'b0;
          end else begin
            latched_status_next = STAT_INCOMPLETE;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage          <= ST_START;
      latched_status <= STAT_INCOMPLETE;
      byte_count     <= '0;
      got_version    <= '0;
      got_target     <= '0;
      size_word      <= '0;
      payload_count  <= '0;
      sink_active    <= 1'b0;
    end else if (fire) begin
      stage          <= stage_next;
      latched_status <= latched_status_next;
      byte_count     <= byte_count_next;
      got_version    <= got_version_next;
      got_target     <= got_target_next;
      size_word      <= size_word_next;
      payload_count  <= payload_count_next;
      sink_active    <= sink_active_next;
    end
  end

  always_comb begin
    result.status        = latched_status_next;
    result.begin_strobe  = b_s;
    result.write_strobe  = w_s;
    result.write_byte    = w_b;
    result.finish_strobe = f_s;
    result.abort_strobe  = a_s;
    result.frame_size    = size_word_next;
    result.write_count   = payload_count_next;
  end

  // abort on a fed byte only tears down a sink that was opened
  a_abort_needs_sink: assert property (@(posedge clk) disable iff (rst)
    fire && item.command == CMD_FEED && result.abort_strobe |-> sink_active)
    else $error("abort without active sink");

  // payload writes only while the sink is open
  a_write_in_payload: assert property (@(posedge clk) disable iff (rst)
    fire && result.write_strobe |-> stage == ST_PAYLOAD && sink_active)
    else $error("write outside payload");

  // a rejection clears the parser
  a_reject_clears: assert property (@(posedge clk) disable iff (rst)
    fire && result.status == STAT_INVALID |=>
      stage == ST_START && payload_count == '0 && !sink_active)
    else $error("state not cleared after rejection");

  // finish is only attempted on the last end byte
  a_finish_at_end: assert property (@(posedge clk) disable iff (rst)
    fire && result.finish_strobe |-> stage == ST_END && byte_count == 4'd3)
    else $error("finish outside end word");

endmodule

`default_nettype wire

FILE: rtl/fusd_out_reg.sv
// result register with valid/stall handshake
// depends on fusd_pkg
`default_nettype none

module fusd_out_reg (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              held_valid,
  input  wire fusd_pkg::result_t next_result,
  output logic                   advance,
  output logic                   fire,
  output logic                   result_valid,
  input  wire logic              result_stall,
  output fusd_pkg::result_t      result
);
  import fusd_pkg::*;

  assign advance = !result_valid || !result_stall;
  assign fire    = held_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= held_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      result <= next_result;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/firmware_update_stream_deframer.sv
// top level of the firmware update stream deframer
// depends on fusd_pkg, fusd_in_reg, fusd_core, fusd_out_reg
//
//   channel  handshake                  payload
//   feed     feed_valid / feed_stall    command, data_byte, sink_accepts
//   result   result_valid / result_stall status, strobes, write_byte, counts
//   config   wr_en                      wr_index, wr_data
//
// one byte per cycle sustained while result_stall is low; a byte's result transaction goes
// through the input register, then the parse logic into the result register
// synchronous reset clears parser state, config registers and both valid flags
// result_stall backs up through the result register into feed_stall in the same cycle
`default_nettype none

module firmware_update_stream_deframer (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               wr_en,
  input  wire fusd_pkg::cfg_idx_t wr_index,
  input  wire logic [31:0]        wr_data,
  input  wire logic               feed_valid,
  output logic                    feed_stall,
  input  wire fusd_pkg::cmd_t     command,
  input  wire logic [7:0]         data_byte,
  input  wire logic               sink_accepts,
  output logic                    result_valid,
  input  wire logic               result_stall,
  output fusd_pkg::status_t       status,
  output logic                    begin_strobe,
  output logic                    write_strobe,
  output logic [7:0]              write_byte,
  output logic                    finish_strobe,
  output logic                    abort_strobe,
  output logic [31:0]             frame_size,
  output logic [31:0]             write_count
);
  import fusd_pkg::*;

  item_t   feed_item, held_item;
  result_t next_result, result;
  logic    held_valid, advance, fire;

  assign feed_item.command      = command;
  assign feed_item.data_byte    = data_byte;
  assign feed_item.sink_accepts = sink_accepts;

  fusd_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .feed_valid (feed_valid),
    .feed_stall (feed_stall),
    .feed_item  (feed_item),
    .advance    (advance),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  fusd_core u_core (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .fire     (fire),
    .item     (held_item),
    .result   (next_result)
  );

  fusd_out_reg u_out_reg (
    .clk          (clk),
    .rst          (rst),
    .held_valid   (held_valid),
    .next_result  (next_result),
    .advance      (advance),
    .fire         (fire),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  assign status        = result.status;
  assign begin_strobe  = result.begin_strobe;
  assign write_strobe  = result.write_strobe;
  assign write_byte    = result.write_byte;
  assign finish_strobe = result.finish_strobe;
  assign abort_strobe  = result.abort_strobe;
  assign frame_size    = result.frame_size;
  assign write_count   = result.write_count;

endmodule

`default_nettype wire

FILE: verif/firmware_update_stream_deframer_tb.sv
// testbench for firmware_update_stream_deframer: frames with random content and injected flaws
// are fed under random idling and stalls, and every result is checked against an internal predictor
// depends on fusd_pkg and the firmware_update_stream_deframer rtl
module testbench;
  import fusd_pkg::*;

  localparam cmd_t CMD_UNUSED = 2'd3;

  typedef enum logic [2:0] {
    STAGE_START, STAGE_META, STAGE_PAYLOAD, STAGE_END, STAGE_DONE
  } stage_t;

  typedef enum int {
    FL_NONE, FL_START, FL_VERSION, FL_TARGET, FL_ZERO_SIZE, FL_BEGIN_REFUSED,
    FL_WRITE_REFUSED, FL_END_BYTE, FL_FINISH_REFUSED, FL_CUT_SHORT, FL_NOISE
  } flaw_t;

  class deframe_scoreboard;
    logic [31:0] start_word, version_word, target_id, end_word;
    stage_t      stage;
    status_t     latched;
    logic [3:0]  count;
    logic [31:0] got_version, got_target, size_word, payload_count;
    logic        sink_active;
    result_t     pending_results[$];
    int          errors;

    function new();
      start_word = '0;
      version_word = '0;
      target_id = '0;
      end_word = '0;
      errors = 0;
      clear_parser();
    endfunction

    function void clear_parser();
      stage = STAGE_START;
      latched = STAT_INCOMPLETE;
      count = '0;
      got_version = '0;
      got_target = '0;
      size_word = '0;
      payload_count = '0;
      sink_active = 1'b0;
    endfunction

    function void set_reg(cfg_idx_t idx, logic [31:0] v);
      case (idx)
        CFG_START_WORD:   start_word = v;
        CFG_VERSION_WORD: version_word = v;
        CFG_TARGET_ID:    target_id = v;
        CFG_END_WORD:     end_word = v;
        default: ;
      endcase
    endfunction

    function logic [7:0] marker_byte(logic [31:0] w, logic [3:0] k);
      return w[8 * k[1:0] +: 8];
    endfunction

    function result_t deframe_step(item_t it);
      result_t res;
      status_t verdict;
      logic [3:0] k;
      res = '0;
      if (it.command == CMD_CLEAR) begin
        clear_parser();
      end else if (it.command == CMD_ABORT) begin
        res.abort_strobe = 1'b1;
        clear_parser();
      end else if (it.command == CMD_FEED && latched != STAT_INVALID) begin
        verdict = STAT_INVALID;
        k = count;
        case (stage)
          STAGE_START: begin
            if (marker_byte(start_word, k) == it.data_byte) begin
              count = k + 4'd1;
              verdict = (count == MARKER_BYTES) ? STAT_COMPLETE : STAT_INCOMPLETE;
            end
          end
          STAGE_META: begin
            if (k < 4) got_version |= 32'(it.data_byte) << (8 * k);
            else if (k < 8) got_target |= 32'(it.data_byte) << (8 * (k - 4));
            else if (k < 12) size_word |= 32'(it.data_byte) << (8 * (k - 8));
            count = k + 4'd1;
            if (count != META_BYTES) begin
              verdict = STAT_INCOMPLETE;
            end else if (got_version == version_word && got_target == target_id &&
                         size_word != 0) begin
              res.begin_strobe = 1'b1;
              if (it.sink_accepts) begin
                sink_active = 1'b1;
                verdict = STAT_COMPLETE;
              end
            end
          end
          STAGE_PAYLOAD: begin
            res.write_strobe = 1'b1;
            res.write_byte = it.data_byte;
            if (it.sink_accepts) begin
              payload_count++;
              verdict = (payload_count == size_word) ? STAT_COMPLETE : STAT_INCOMPLETE;
            end
          end
          STAGE_END: begin
            if (marker_byte(end_word, k) == it.data_byte) begin
              count = k + 4'd1;
              if (count == MARKER_BYTES) begin
                res.finish_strobe = 1'b1;
                verdict = it.sink_accepts ? STAT_COMPLETE : STAT_INVALID;
              end else begin
                verdict = STAT_INCOMPLETE;
              end
            end
          end
          default: ;
        endcase
        if (verdict == STAT_COMPLETE) begin
          if (stage == STAGE_END) begin
            stage = STAGE_DONE;
            sink_active = 1'b0;
            latched = STAT_COMPLETE;
          end else begin
            count = '0;
            stage = stage_t'(stage + 1);
            latched = STAT_INCOMPLETE;
          end
        end else if (verdict == STAT_INVALID) begin
          if (sink_active) res.abort_strobe = 1'b1;
          clear_parser();
          latched = STAT_INVALID;
        end else begin
          latched = STAT_INCOMPLETE;
        end
      end
      res.status = latched;
      res.frame_size = size_word;
      res.write_count = payload_count;
      return res;
    endfunction

    function void note_item(item_t it);
      pending_results.push_back(deframe_step(it));
    endfunction

    function int outstanding();
      return pending_results.size();
    endfunction

    task report(string msg);
      errors++;
      $display("error at %0t: %s", $time, msg);
    endtask

    task check_result(result_t got);
      result_t want;
      string diffs;
      if (pending_results.size() == 0) begin
        report("result transaction with nothing outstanding");
        return;
      end
      want = pending_results.pop_front();
      diffs = "";
      if (got.status !== want.status)
        diffs = {diffs, $sformatf(" status %0d/%0d", got.status, want.status)};
      if (got.begin_strobe !== want.begin_strobe)
        diffs = {diffs, $sformatf(" begin %0b/%0b", got.begin_strobe, want.begin_strobe)};
      if (got.write_strobe !== want.write_strobe)
        diffs = {diffs, $sformatf(" write %0b/%0b", got.write_strobe, want.write_strobe)};
      if (got.write_byte !== want.write_byte)
        diffs = {diffs, $sformatf(" write_byte %h/%h", got.write_byte, want.write_byte)};
      if (got.finish_strobe !== want.finish_strobe)
        diffs = {diffs, $sformatf(" finish %0b/%0b", got.finish_strobe, want.finish_strobe)};
      if (got.abort_strobe !== want.abort_strobe)
        diffs = {diffs, $sformatf(" abort %0b/%0b", got.abort_strobe, want.abort_strobe)};
      if (got.frame_size !== want.frame_size)
        diffs = {diffs, $sformatf(" size %h/%h", got.frame_size, want.frame_size)};
      if (got.write_count !== want.write_count)
        diffs = {diffs, $sformatf(" written %h/%h", got.write_count, want.write_count)};
      if (diffs != "") report({"result field (got/expected):", diffs});
    endtask
  endclass

  logic        clk;
  logic        rst = 1'b1;
  logic        wr_en = 1'b0;
  cfg_idx_t    wr_index = CFG_START_WORD;
  logic [31:0] wr_data = '0;
  logic        feed_valid = 1'b0;
  logic        feed_stall;
  cmd_t        command = CMD_FEED;
  logic [7:0]  data_byte = '0;
  logic        sink_accepts = 1'b0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  status_t     status;
  logic        begin_strobe, write_strobe, finish_strobe, abort_strobe;
  logic [7:0]  write_byte;
  logic [31:0] frame_size, write_count;

  deframe_scoreboard sb = new();
  item_t feed_stream[$];
  int    send_idle_pct = 0;
  int    recv_stall_pct = 0;
  int    items_sent = 0;

  firmware_update_stream_deframer uut (
    .clk, .rst, .wr_en, .wr_index, .wr_data,
    .feed_valid, .feed_stall, .command, .data_byte, .sink_accepts,
    .result_valid, .result_stall, .status, .begin_strobe, .write_strobe, .write_byte,
    .finish_strobe, .abort_strobe, .frame_size, .write_count
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3000000;
    $display("firmware_update_stream_deframer: mismatch");
    $finish;
  end

  always @(posedge clk) begin
    result_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (feed_valid && !feed_stall)
        sb.note_item(item_t'{command, data_byte, sink_accepts});
      if (result_valid && !result_stall)
        sb.check_result(result_t'{status, begin_strobe, write_strobe, write_byte,
                                  finish_strobe, abort_strobe, frame_size, write_count});
    end
  end

  task automatic write_regs(logic [31:0] sw, logic [31:0] fv, logic [31:0] ti,
                            logic [31:0] ew);
    logic [31:0] vals [CFG_COUNT];
    vals = '{sw, fv, ti, ew};
    for (int i = 0; i < CFG_COUNT; i++) begin
      wr_en <= 1'b1;
      wr_index <= cfg_idx_t'(i);
      wr_data <= vals[i];
      @(posedge clk);
      sb.set_reg(cfg_idx_t'(i), vals[i]);
    end
    wr_en <= 1'b0;
  endtask

  task automatic push(cmd_t c, logic [7:0] d, logic acc);
    feed_stream.push_back(item_t'{c, d, acc});
  endtask

  task automatic send_item(item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      feed_valid <= 1'b0;
      @(posedge clk);
    end
    feed_valid <= 1'b1;
    command <= it.command;
    data_byte <= it.data_byte;
    sink_accepts <= it.sink_accepts;
    @(posedge clk);
    while (feed_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_stream();
    while (feed_stream.size() != 0) send_item(feed_stream.pop_front());
  endtask

  task automatic settle();
    feed_valid <= 1'b0;
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  task automatic build_frame(flaw_t flaw, logic [31:0] size);
    logic [31:0] ver, tgt;
    logic [95:0] meta;
    logic [7:0]  b;
    int          flip_at, w_at, base, cut;
    base = feed_stream.size();
    if (flaw == FL_NOISE) begin
      repeat ($urandom_range(8, 1))
        push(cmd_t'($urandom_range(3)), 8'($urandom), 1'($urandom));
      return;
    end
    ver = sb.version_word;
    tgt = sb.target_id;
    flip_at = $urandom_range(3);
    if (flaw == FL_VERSION) ver ^= 32'h1 << $urandom_range(31);
    if (flaw == FL_TARGET) tgt ^= 32'h1 << $urandom_range(31);
    if (flaw == FL_ZERO_SIZE) size = '0;
    if (flaw == FL_CUT_SHORT) size = $urandom | 32'h1;
    w_at = (size != 0 && size <= 64) ? $urandom_range(size - 1) : 0;
    for (int k = 0; k < 4; k++) begin
      b = sb.start_word[8 * k +: 8];
      if (flaw == FL_START && k == flip_at) b ^= 8'h1 << $urandom_range(7);
      push(CMD_FEED, b, 1'($urandom));
    end
    meta = {size, tgt, ver};
    for (int k = 0; k < 12; k++)
      push(CMD_FEED, meta[8 * k +: 8], (k == 11) ? (flaw != FL_BEGIN_REFUSED) : 1'($urandom));
    for (int i = 0; i < size && i < 64; i++)
      push(CMD_FEED, 8'($urandom), !(flaw == FL_WRITE_REFUSED && i == w_at));
    for (int k = 0; k < 4; k++) begin
      b = sb.end_word[8 * k +: 8];
      if (flaw == FL_END_BYTE && k == flip_at) b ^= 8'h1 << $urandom_range(7);
      push(CMD_FEED, b, (k == 3) ? (flaw != FL_FINISH_REFUSED) : 1'($urandom));
    end
    if (flaw == FL_CUT_SHORT) begin
      cut = $urandom_range(feed_stream.size() - 1, base + 1);
      while (feed_stream.size() > cut) void'(feed_stream.pop_back());
    end
  endtask

  task automatic close_frame();
    if ($urandom_range(3) == 0)
      repeat ($urandom_range(3, 1)) push(CMD_FEED, 8'($urandom), 1'($urandom));
    if ($urandom_range(7) == 0) push(CMD_UNUSED, 8'($urandom), 1'($urandom));
    push($urandom_range(1) ? CMD_ABORT : CMD_CLEAR, 8'($urandom), 1'($urandom));
  endtask

  function automatic flaw_t pick_flaw();
    int roll;
    roll = $urandom_range(19);
    return (roll < 10) ? FL_NONE : flaw_t'(roll - 9);
  endfunction

  function automatic logic [31:0] pick_size();
    return ($urandom_range(9) == 0) ? $urandom_range(48, 7) : $urandom_range(6, 1);
  endfunction

  initial begin
    int frames;
    int idle_pct [4];
    int stall_pct [4];
    idle_pct = '{0, 48, 0, 12};
    stall_pct = '{0, 0, 48, 12};
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed: one minimal frame, then the done, invalid and command corner cases
    write_regs(32'h00FF_5AA5, 32'hFFFF_FFFF, 32'h0000_0000, 32'h80C3_3C01);
    build_frame(FL_NONE, 32'd1);
    push(CMD_FEED, 8'hFF, 1'b1);
    push(CMD_UNUSED, 8'h00, 1'b0);
    push(CMD_FEED, 8'h00, 1'b1);
    push(CMD_ABORT, 8'hFF, 1'b0);
    push(CMD_CLEAR, 8'h00, 1'b1);
    send_stream();

    for (int p = 0; p < 4; p++) begin
      settle();
      if (p == 1) write_regs('0, '0, '0, '0);
      else if (p == 2) write_regs('1, '1, '1, '1);
      else write_regs($urandom, $urandom, $urandom, $urandom);
      send_idle_pct = idle_pct[p];
      recv_stall_pct = stall_pct[p];
      frames = 0;
      while (items_sent < 280 * (p + 1)) begin
        build_frame(pick_flaw(), pick_size());
        close_frame();
        send_stream();
        frames++;
        if (frames % 12 == 0) settle();
      end
    end

    settle();
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("firmware_update_stream_deframer: match");
    end else begin
      $display("firmware_update_stream_deframer: mismatch");
    end
    $finish;
  end
endmodule

FILE: firmware_update_stream_deframer.f
rtl/fusd_pkg.sv
rtl/fusd_in_reg.sv
rtl/fusd_core.sv
rtl/fusd_out_reg.sv
rtl/firmware_update_stream_deframer.sv
verif/firmware_update_stream_deframer_tb.sv
